@@ rtl/efd_pkg.sv @@
// Package for the escaped frame deframer: payload structs, register map,
// reset codes and sizing constants. Depends on nothing; every rtl file imports it.
package efd_pkg;

	// Default frame length limit and depth of the front-to-back queue
	localparam int DEF_MAX_FRAME_LEN = 128;
	localparam int QUEUE_DEPTH       = 4;

	// Configuration port sizing
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	// Register indexes (word address paddr[4:2])
	localparam logic [2:0] REG_ESCAPE     = 3'd0;
	localparam logic [2:0] REG_START_BUS  = 3'd1;
	localparam logic [2:0] REG_START_MQTT = 3'd2;
	localparam logic [2:0] REG_START_BENC = 3'd3;
	localparam logic [2:0] REG_START_MENC = 3'd4;
	localparam logic [2:0] REG_END        = 3'd5;
	localparam logic [2:0] REG_SINGLE_ESC = 3'd6;
	localparam logic [2:0] REG_DOUBLE_ESC = 3'd7;

	// Register reset values
	localparam logic [7:0] RST_ESCAPE     = 8'd27;
	localparam logic [7:0] RST_START_BUS  = 8'd2;
	localparam logic [7:0] RST_START_MQTT = 8'd3;
	localparam logic [7:0] RST_START_BENC = 8'd4;
	localparam logic [7:0] RST_START_MENC = 8'd5;
	localparam logic [7:0] RST_END        = 8'd6;
	localparam logic [7:0] RST_SINGLE_ESC = 8'd7;
	localparam logic [7:0] RST_DOUBLE_ESC = 8'd8;

	// Input action and result kind codes
	localparam logic ACT_BYTE     = 1'b0;
	localparam logic ACT_CLEAR    = 1'b1;
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_DONE    = 1'b1;

	// Control codes as seen by the decoder
	typedef struct packed {
		logic [7:0] escape_code;
		logic [7:0] start_bus_code;
		logic [7:0] start_mqtt_code;
		logic [7:0] start_bus_enc_code;
		logic [7:0] start_mqtt_enc_code;
		logic [7:0] end_code;
		logic [7:0] single_escape_code;
		logic [7:0] double_escape_code;
	} efd_cfg_t;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} efd_in_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [6:0]  byte_index;
		logic [7:0]  frame_length;
		logic        is_bus_message;
		logic        is_encrypted;
		logic [15:0] error_total;
		logic        last;
	} efd_out_t;

	// One queue entry: first result, plus a flag for a second escape byte
	typedef struct packed {
		logic     two;
		efd_out_t res;
	} efd_entry_t;

endpackage

@@ rtl/efd_regs.sv @@
// Control code registers behind the APB-style configuration port.
// Depends on efd_pkg.
module efd_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [efd_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [efd_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [efd_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	output efd_pkg::efd_cfg_t               cfg
);
	import efd_pkg::*;

	efd_cfg_t   cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;
	logic [7:0] rd_val;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.escape_code         <= RST_ESCAPE;
			cfg_q.start_bus_code      <= RST_START_BUS;
			cfg_q.start_mqtt_code     <= RST_START_MQTT;
			cfg_q.start_bus_enc_code  <= RST_START_BENC;
			cfg_q.start_mqtt_enc_code <= RST_START_MENC;
			cfg_q.end_code            <= RST_END;
			cfg_q.single_escape_code  <= RST_SINGLE_ESC;
			cfg_q.double_escape_code  <= RST_DOUBLE_ESC;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ESCAPE:     cfg_q.escape_code         <= pwdata[7:0];
				REG_START_BUS:  cfg_q.start_bus_code      <= pwdata[7:0];
				REG_START_MQTT: cfg_q.start_mqtt_code     <= pwdata[7:0];
				REG_START_BENC: cfg_q.start_bus_enc_code  <= pwdata[7:0];
				REG_START_MENC: cfg_q.start_mqtt_enc_code <= pwdata[7:0];
				REG_END:        cfg_q.end_code            <= pwdata[7:0];
				REG_SINGLE_ESC: cfg_q.single_escape_code  <= pwdata[7:0];
				REG_DOUBLE_ESC: cfg_q.double_escape_code  <= pwdata[7:0];
				default:        cfg_q.escape_code         <= cfg_q.escape_code;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (reg_idx)
			REG_ESCAPE:     rd_val = cfg_q.escape_code;
			REG_START_BUS:  rd_val = cfg_q.start_bus_code;
			REG_START_MQTT: rd_val = cfg_q.start_mqtt_code;
			REG_START_BENC: rd_val = cfg_q.start_bus_enc_code;
			REG_START_MENC: rd_val = cfg_q.start_mqtt_enc_code;
			REG_END:        rd_val = cfg_q.end_code;
			REG_SINGLE_ESC: rd_val = cfg_q.single_escape_code;
			REG_DOUBLE_ESC: rd_val = cfg_q.double_escape_code;
			default:        rd_val = 8'd0;
		endcase
	end

	assign prdata = {{(CFG_DATA_W-8){1'b0}}, rd_val};

endmodule

@@ rtl/efd_front.sv @@
// Front end: accepts line bytes, tracks escape and frame state, counts
// errors and pushes one queue entry per byte that yields results. Depends on efd_pkg.
module efd_front #(
	parameter int MAX_FRAME_LEN = efd_pkg::DEF_MAX_FRAME_LEN
) (
	input  logic                clk,
	input  logic                arst_n,
	input  efd_pkg::efd_cfg_t   cfg,
	input  logic                item_valid,
	output logic                item_ready,
	input  efd_pkg::efd_in_t    item,
	input  logic                q_full,
	output logic                push,
	output efd_pkg::efd_entry_t push_entry
);
	import efd_pkg::*;

	localparam int LW = $clog2(MAX_FRAME_LEN + 1);
	localparam logic [LW:0] MAX_W = (LW+1)'(MAX_FRAME_LEN);

	logic          esc_q, open_q, bus_q, enc_q;
	logic [LW-1:0] len_q;
	logic [15:0]   err_q;

	logic          esc_d, open_d, bus_d, enc_d;
	logic [LW-1:0] len_d;
	logic [15:0]   err_d;
	logic          err_hit, emit, two, accept;
	logic          is_start, full;
	logic [LW:0]   len_p1;
	logic [7:0]    c;
	efd_entry_t    ent;

	assign item_ready = !q_full;
	assign accept     = item_valid && item_ready;
	assign c          = item.rx_byte;
	assign len_p1     = {1'b0, len_q} + (LW+1)'(1);
	assign full       = {1'b0, len_q} >= MAX_W;
	assign is_start   = (c == cfg.start_bus_code) || (c == cfg.start_mqtt_code) ||
		(c == cfg.start_bus_enc_code) || (c == cfg.start_mqtt_enc_code);

	// Classify the byte and work out next state and the entry to queue
	always_comb begin
		esc_d   = esc_q;
		open_d  = open_q;
		bus_d   = bus_q;
		enc_d   = enc_q;
		len_d   = len_q;
		err_hit = 1'b0;
		emit    = 1'b0;
		two     = 1'b0;
		ent     = '0;
		ent.res.is_bus_message = bus_q;
		ent.res.is_encrypted   = enc_q;
		ent.res.byte_index     = 7'(len_q);
		if (item.action == ACT_CLEAR) begin
			esc_d  = 1'b0;
			open_d = 1'b0;
			bus_d  = 1'b0;
			enc_d  = 1'b0;
			len_d  = '0;
		end else if (full) begin
			// frame at its limit: drop everything until a clear
		end else if (esc_q) begin
			esc_d = 1'b0;
			if (is_start) begin
				err_hit = open_q;
				open_d  = 1'b1;
				len_d   = '0;
				bus_d   = (c == cfg.start_bus_code) || (c == cfg.start_bus_enc_code);
				enc_d   = (c == cfg.start_bus_enc_code) || (c == cfg.start_mqtt_enc_code);
			end else if (c == cfg.end_code) begin
				if (!open_q) begin
					err_hit = 1'b1;
				end else begin
					emit                 = 1'b1;
					open_d               = 1'b0;
					ent.res.kind         = KIND_DONE;
					ent.res.byte_index   = 7'd0;
					ent.res.frame_length = 8'(len_q);
				end
			end else if (c == cfg.single_escape_code) begin
				if (!open_q) begin
					err_hit = 1'b1;
				end else begin
					emit                 = 1'b1;
					ent.res.payload_byte = cfg.escape_code;
					len_d                = LW'(len_p1);
				end
			end else if (c == cfg.double_escape_code) begin
				if (!open_q) begin
					err_hit = 1'b1;
				end else begin
					emit                 = 1'b1;
					two                  = len_p1 < MAX_W;
					ent.res.payload_byte = cfg.escape_code;
					len_d                = two ? LW'(len_p1 + (LW+1)'(1)) : LW'(len_p1);
				end
			end else begin
				err_hit = 1'b1;
			end
		end else if (c == cfg.escape_code) begin
			esc_d = 1'b1;
		end else if (!open_q) begin
			err_hit = 1'b1;
		end else begin
			emit                 = 1'b1;
			ent.res.payload_byte = c;
			len_d                = LW'(len_p1);
		end
		err_d = (err_hit && (err_q != 16'hFFFF)) ? err_q + 16'd1 : err_q;
		ent.two             = two;
		ent.res.last        = !two;
		ent.res.error_total = err_d;
	end

	assign push       = accept && emit;
	assign push_entry = ent;

	// Advance frame state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= 1'b0;
			open_q <= 1'b0;
			bus_q  <= 1'b0;
			enc_q  <= 1'b0;
			len_q  <= '0;
			err_q  <= '0;
		end else if (accept) begin
			esc_q  <= esc_d;
			open_q <= open_d;
			bus_q  <= bus_d;
			enc_q  <= enc_d;
			len_q  <= len_d;
			err_q  <= err_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, len_q} <= MAX_W)
		else $error("frame length past its limit");
	a_err_mono: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> err_q >= $past(err_q))
		else $error("error count went backwards");
`endif

endmodule

@@ rtl/efd_fifo.sv @@
// Short queue of decoded entries between front and back end.
// Depends on efd_pkg.
module efd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  efd_pkg::efd_entry_t push_entry,
	input  logic                pop,
	output efd_pkg::efd_entry_t head,
	output logic                empty,
	output logic                full
);
	import efd_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);

	efd_entry_t    mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign empty = count_q == '0;
	assign full  = count_q == DEPTH_C;
	assign head  = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("queue pushed when full or popped when empty");
`endif

endmodule

@@ rtl/efd_back.sv @@
// Back end: pops queue entries and presents results through an output
// register, splitting a double escape into two transfers. Depends on efd_pkg.
module efd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  efd_pkg::efd_entry_t head,
	input  logic                empty,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_ready,
	output efd_pkg::efd_out_t   result
);
	import efd_pkg::*;

	efd_out_t out_q, second_q, second_d;
	logic     valid_q, pend_q, load;

	// Output register is free when empty or being taken
	assign load = !valid_q || result_ready;
	assign pop  = load && !pend_q && !empty;

	// Second literal escape: next index, closes the item
	always_comb begin
		second_d            = head.res;
		second_d.byte_index = head.res.byte_index + 7'd1;
		second_d.last       = 1'b1;
	end

	// Hold result data
	always_ff @(posedge clk) begin
		if (load && pend_q) begin
			out_q <= second_q;
		end else if (pop) begin
			out_q    <= head.res;
			second_q <= second_d;
		end
	end

	// Track output valid and pending second result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else begin
				valid_q <= pop;
				pend_q  <= pop && head.two;
			end
		end
	end

	assign result_valid = valid_q;
	assign result       = out_q;

`ifndef NO_ASSERTIONS
	a_pend_shown: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> valid_q && !out_q.last)
		else $error("second result pending behind a final one");
	a_follow_on: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && result_ready && !out_q.last |=> valid_q && out_q.last)
		else $error("first of two results not followed by its second");
`endif

endmodule

@@ rtl/escaped_frame_deframer.sv @@
// Escaped frame deframer: takes one line byte or clear item per cycle, unless
// the queue is full, and strips escape framing, emitting payload bytes with
// their index and a frame-done record with length and flags. Results leave at
// one per clock while the output is taken and the queue holds entries, except
// a double escape, whose two literal bytes leave as two transfers from the back
// end. A four-entry queue between the two absorbs that and output stalls; the
// front holds off only when the queue is full.
// Depends on efd_pkg, efd_regs, efd_front, efd_fifo and efd_back.
module escaped_frame_deframer #(
	parameter int MAX_FRAME_LEN = efd_pkg::DEF_MAX_FRAME_LEN
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [efd_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [efd_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [efd_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  efd_pkg::efd_in_t                item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output efd_pkg::efd_out_t               result
);
	import efd_pkg::*;

	efd_cfg_t   cfg;
	efd_entry_t push_entry, head;
	logic       push, pop, q_full, q_empty;

	efd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	efd_front #(
		.MAX_FRAME_LEN (MAX_FRAME_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	efd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (q_empty),
		.full       (q_full)
	);

	efd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (q_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
